FILE: sv/iaqu_pkg.sv
// ----------------------------------------------------------------------------
// iaqu_pkg: shared types and constants of the attitude quaternion update
// Holds the sample and result transaction types, the register indexes and
// the fixed-point constants of the datapath.
// ----------------------------------------------------------------------------
package iaqu_pkg;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [31:0] gyro_x;
		logic signed [31:0] gyro_y;
		logic signed [31:0] gyro_z;
		logic        [31:0] tick_now;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic               accel_invalid;
	} quat_t;

	typedef enum logic [1:0] {
		REG_KP        = 2'd0,
		REG_KI        = 2'd1,
		REG_HALF_TICK = 2'd2
	} reg_idx_t;

	localparam logic [22:0] KP_RESET        = 23'd65536;
	localparam logic [22:0] KI_RESET        = 23'd34734;
	localparam logic [31:0] HALF_TICK_RESET = 32'd2147484;

	// pi/180 in Q0.32, reciprocal of three for a 33 bit dividend
	localparam logic signed [33:0] DEG2RAD_Q32 = 34'sd74961321;
	localparam logic signed [33:0] DIV3_MAGIC  = 34'sd2863311531;

	localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
	localparam logic signed [33:0] TWO_Q30     = 34'sd2147483648;
	localparam logic        [33:0] THREE_Q30   = 34'd3221225472;

	// two-segment chord seed of 1/sqrt(x) over [1,4)
	localparam logic signed [33:0] CHORD_LO_SLOPE = 34'sd314491697;
	localparam logic signed [33:0] CHORD_HI_SLOPE = 34'sd111189605;
	localparam logic        [31:0] CHORD_HI_BASE  = 32'd759250125;

endpackage

FILE: sv/imu_attitude_quaternion_update.sv
// ----------------------------------------------------------------------------
// imu_attitude_quaternion_update: six-axis complementary attitude filter
// Smooths each sample, corrects the gyro rate from the gravity error and
// integrates, renormalises and returns the attitude quaternion in Q2.30.
// ----------------------------------------------------------------------------
// One sample transaction in gives one quaternion transaction out. The block
// takes a sample only while it is idle (sample_stall low) and then works on
// it until its result is written to the output register; the correction is
// skipped when the smoothed acceleration is zero. Every product goes through
// one shared 34x34 bit signed multiplier with a registered result, stepped by
// the sequencer below, so each product is issued and then consumed. Each
// inverse square root runs the normalising shifts, the chord seed and then
// NEWTON_STEPS Newton steps. Each of the seven time-scaled products also runs
// the wide multiply sub-sequence. A finished quaternion waits in the output
// register, so the next sample is accepted while the previous result is still
// stalled; the block only holds at its final step if that earlier result is
// still there.
// Configuration writes are always taken (cfg_ready is high) and must only be
// issued while the block is idle.
module imu_attitude_quaternion_update
	import iaqu_pkg::*;
#(
	parameter int NEWTON_STEPS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        quat_valid,
	input  logic        quat_stall,
	output quat_t       quat,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NsW = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
	localparam logic [NsW-1:0] NsLast = NsW'(NEWTON_STEPS - 1);

	typedef enum logic [5:0] {
		S_IDLE, S_SM_ABS, S_SM_MUL, S_SM_FIX, S_GY_MUL, S_GY_WR, S_H_MUL, S_H_WR,
		S_AS_MUL, S_AS_ACC, S_IS_NORM, S_IS_SEED, S_IS_Y, S_NT_SQ, S_NT_XY, S_NT_T,
		S_NT_YT, S_NT_WR, S_U_MUL, S_U_WR, S_V_MUL, S_V_ACC, S_E_MUL, S_E_ACC,
		S_I_MUL, S_I_GET, S_MT_ABS, S_MT_HI, S_MT_LO, S_MT_SUM, S_MT_SGN, S_I_WR,
		S_W_MUL, S_W_WR, S_T_MUL, S_T_ACC, S_T_WR, S_QS_MUL, S_QS_ACC, S_Q_MUL,
		S_Q_WR, S_DONE
	} state_t;

	function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
		return {{4{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Architectural state
	state_t             state_q;
	logic signed [31:0] smp_q [6];
	logic signed [31:0] att_q [4];
	logic signed [31:0] int_q [3];
	logic        [31:0] last_tick_q;
	logic        [22:0] kp_q;
	logic        [22:0] ki_q;
	logic        [31:0] hts_q;

	// Working registers of one transaction
	sample_t            in_q;
	logic        [31:0] dt_q;
	logic        [31:0] h_q;
	logic               invalid_q;
	logic        [2:0]  idx_q;
	logic        [3:0]  k_q;
	logic        [1:0]  dst_q;
	logic               pass_q;
	logic               mt_ret_q;
	logic               sm_neg_q;
	logic        [32:0] sm_mag_q;
	logic signed [31:0] g_q [3];
	logic signed [31:0] u_q [3];
	logic signed [33:0] v_q [3];
	logic signed [33:0] e_q [3];
	logic signed [31:0] w_q [3];
	logic signed [31:0] t_q [4];
	logic signed [67:0] acc_q;
	logic signed [67:0] prod_q;
	logic        [63:0] ns_m_q;
	logic signed [5:0]  ns_j_q;
	logic        [4:0]  sh_q;
	logic        [31:0] x_q;
	logic        [31:0] y_q;
	logic        [31:0] tn_q;
	logic [NsW-1:0]     nstep_q;
	logic signed [67:0] mt_a_q;
	logic               mt_neg_q;
	logic        [63:0] mt_m_q;
	logic        [63:0] mt_hi_q;
	logic signed [63:0] mt_r_q;
	logic               quat_valid_q;
	quat_t              quat_q;

	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic        [1:0]  tab_a;
	logic        [1:0]  tab_b;
	logic               tab_neg;
	logic               tab_last;
	logic signed [67:0] acc_nxt;
	logic signed [31:0] in_sel;
	logic signed [33:0] sm_sum;
	logic        [31:0] seed_x;
	logic        [33:0] xy2;
	logic        [64:0] mt_sum;
	logic signed [63:0] mt_shr;
	logic signed [48:0] t_sum;
	logic signed [35:0] i_sum;
	logic signed [35:0] w_corr;
	logic signed [35:0] w_sum;
	logic signed [67:0] p_sh;

	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign quat_valid   = quat_valid_q;
	assign quat         = quat_q;

	// Pick the raw axis being smoothed
	always_comb begin
		case (idx_q)
			3'd0:    in_sel = in_q.accel_x;
			3'd1:    in_sel = in_q.accel_y;
			3'd2:    in_sel = in_q.accel_z;
			3'd3:    in_sel = in_q.gyro_x;
			3'd4:    in_sel = in_q.gyro_y;
			default: in_sel = in_q.gyro_z;
		endcase
	end

	// Operand selection of the product sequences: gravity, error, quaternion rate
	always_comb begin
		tab_a    = 2'd0;
		tab_b    = 2'd0;
		tab_neg  = 1'b0;
		tab_last = 1'b0;
		case (state_q)
			S_V_MUL, S_V_ACC: begin
				case (k_q)
					4'd0:    begin tab_a = 2'd1; tab_b = 2'd3; end
					4'd1:    begin tab_a = 2'd0; tab_b = 2'd2; tab_neg = 1'b1; tab_last = 1'b1; end
					4'd2:    begin tab_a = 2'd0; tab_b = 2'd1; end
					4'd3:    begin tab_a = 2'd2; tab_b = 2'd3; tab_last = 1'b1; end
					4'd4:    begin tab_a = 2'd0; tab_b = 2'd0; end
					4'd5:    begin tab_a = 2'd1; tab_b = 2'd1; tab_neg = 1'b1; end
					4'd6:    begin tab_a = 2'd2; tab_b = 2'd2; tab_neg = 1'b1; end
					default: begin tab_a = 2'd3; tab_b = 2'd3; tab_last = 1'b1; end
				endcase
			end
			S_E_MUL, S_E_ACC: begin
				case (k_q)
					4'd0:    begin tab_a = 2'd1; tab_b = 2'd2; end
					4'd1:    begin tab_a = 2'd2; tab_b = 2'd1; tab_neg = 1'b1; tab_last = 1'b1; end
					4'd2:    begin tab_a = 2'd2; tab_b = 2'd0; end
					4'd3:    begin tab_a = 2'd0; tab_b = 2'd2; tab_neg = 1'b1; tab_last = 1'b1; end
					4'd4:    begin tab_a = 2'd0; tab_b = 2'd1; end
					default: begin tab_a = 2'd1; tab_b = 2'd0; tab_neg = 1'b1; tab_last = 1'b1; end
				endcase
			end
			S_T_MUL, S_T_ACC: begin
				case (k_q)
					4'd0:    begin tab_a = 2'd1; tab_b = 2'd0; tab_neg = 1'b1; end
					4'd1:    begin tab_a = 2'd2; tab_b = 2'd1; tab_neg = 1'b1; end
					4'd2:    begin tab_a = 2'd3; tab_b = 2'd2; tab_neg = 1'b1; tab_last = 1'b1; end
					4'd3:    begin tab_a = 2'd0; tab_b = 2'd0; end
					4'd4:    begin tab_a = 2'd2; tab_b = 2'd2; end
					4'd5:    begin tab_a = 2'd3; tab_b = 2'd1; tab_neg = 1'b1; tab_last = 1'b1; end
					4'd6:    begin tab_a = 2'd0; tab_b = 2'd1; end
					4'd7:    begin tab_a = 2'd1; tab_b = 2'd2; tab_neg = 1'b1; end
					4'd8:    begin tab_a = 2'd3; tab_b = 2'd0; tab_last = 1'b1; end
					4'd9:    begin tab_a = 2'd0; tab_b = 2'd2; end
					4'd10:   begin tab_a = 2'd1; tab_b = 2'd1; end
					default: begin tab_a = 2'd2; tab_b = 2'd0; tab_neg = 1'b1; tab_last = 1'b1; end
				endcase
			end
			default: begin
				tab_a = 2'd0;
			end
		endcase
	end

	// Shared multiplier operands
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		seed_x = ns_m_q[61:30];
		case (state_q)
			S_SM_MUL: begin mul_a = {1'b0, sm_mag_q}; mul_b = DIV3_MAGIC; end
			S_GY_MUL: begin mul_a = sx34(smp_q[3'(idx_q + 3'd3)]); mul_b = DEG2RAD_Q32; end
			S_H_MUL:  begin mul_a = {2'b0, dt_q}; mul_b = {2'b0, hts_q}; end
			S_AS_MUL: begin mul_a = sx34(smp_q[idx_q]); mul_b = sx34(smp_q[idx_q]); end
			S_IS_SEED: begin
				if (!seed_x[31]) begin
					mul_a = {2'b0, seed_x} - ONE_Q30;
					mul_b = CHORD_LO_SLOPE;
				end else begin
					mul_a = {2'b0, seed_x} - TWO_Q30;
					mul_b = CHORD_HI_SLOPE;
				end
			end
			S_NT_SQ:  begin mul_a = {2'b0, y_q}; mul_b = {2'b0, y_q}; end
			S_NT_XY:  begin mul_a = {2'b0, x_q}; mul_b = prod_q[63:30]; end
			S_NT_YT:  begin mul_a = {2'b0, y_q}; mul_b = {2'b0, tn_q}; end
			S_U_MUL:  begin mul_a = sx34(smp_q[idx_q]); mul_b = {2'b0, y_q}; end
			S_V_MUL:  begin mul_a = sx34(att_q[tab_a]); mul_b = sx34(att_q[tab_b]); end
			S_E_MUL:  begin mul_a = sx34(u_q[tab_a]); mul_b = v_q[tab_b]; end
			S_I_MUL:  begin mul_a = e_q[idx_q[1:0]]; mul_b = {11'b0, ki_q}; end
			S_MT_HI:  begin mul_a = {2'b0, mt_m_q[63:32]}; mul_b = {2'b0, h_q}; end
			S_MT_LO:  begin mul_a = {2'b0, mt_m_q[31:0]}; mul_b = {2'b0, h_q}; end
			S_W_MUL:  begin mul_a = e_q[idx_q[1:0]]; mul_b = {11'b0, kp_q}; end
			S_T_MUL:  begin mul_a = sx34(att_q[tab_a]); mul_b = sx34(w_q[tab_b]); end
			S_QS_MUL: begin mul_a = sx34(t_q[idx_q[1:0]]); mul_b = sx34(t_q[idx_q[1:0]]); end
			S_Q_MUL:  begin mul_a = sx34(t_q[idx_q[1:0]]); mul_b = {2'b0, y_q}; end
			default:  begin mul_a = '0; end
		endcase
	end

	// Datapath terms consumed by the sequencer
	assign acc_nxt = tab_neg ? (acc_q - prod_q) : (acc_q + prod_q);
	assign sm_sum  = sx34(in_sel) + (sx34(smp_q[idx_q]) <<< 1);
	assign xy2     = prod_q[63:30];
	assign mt_sum  = {1'b0, mt_hi_q} + {33'b0, prod_q[63:32]};
	assign mt_shr  = mt_r_q >>> 16;
	assign t_sum   = {{17{att_q[dst_q][31]}}, att_q[dst_q]} + mt_shr[48:0];
	assign i_sum   = sx36(int_q[idx_q[1:0]]) + 36'(mt_r_q >>> 30);
	assign w_corr  = invalid_q ? 36'sd0 : (36'(prod_q >>> 30) + sx36(int_q[idx_q[1:0]]));
	assign w_sum   = sx36(g_q[idx_q[1:0]]) + w_corr;
	assign p_sh    = prod_q >>> sh_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= KP_RESET;
			ki_q  <= KI_RESET;
			hts_q <= HALF_TICK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KP:        kp_q  <= cfg_data[22:0];
				REG_KI:        ki_q  <= cfg_data[22:0];
				REG_HALF_TICK: hts_q <= cfg_data;
				default:       kp_q  <= kp_q;
			endcase
		end
	end

	// Sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int i = 0; i < 6; i++) smp_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				int_q[i] <= '0;
				g_q[i]   <= '0;
				u_q[i]   <= '0;
				v_q[i]   <= '0;
				e_q[i]   <= '0;
				w_q[i]   <= '0;
			end
			att_q[0]     <= ONE_Q30[31:0];
			att_q[1]     <= '0;
			att_q[2]     <= '0;
			att_q[3]     <= '0;
			for (int i = 0; i < 4; i++) t_q[i] <= '0;
			last_tick_q  <= '0;
			in_q         <= '0;
			dt_q         <= '0;
			h_q          <= '0;
			invalid_q    <= 1'b0;
			idx_q        <= '0;
			k_q          <= '0;
			dst_q        <= '0;
			pass_q       <= 1'b0;
			mt_ret_q     <= 1'b0;
			sm_neg_q     <= 1'b0;
			sm_mag_q     <= '0;
			acc_q        <= '0;
			prod_q       <= '0;
			ns_m_q       <= '0;
			ns_j_q       <= '0;
			sh_q         <= '0;
			x_q          <= '0;
			y_q          <= '0;
			tn_q         <= '0;
			nstep_q      <= '0;
			mt_a_q       <= '0;
			mt_neg_q     <= 1'b0;
			mt_m_q       <= '0;
			mt_hi_q      <= '0;
			mt_r_q       <= '0;
			quat_valid_q <= 1'b0;
			quat_q       <= '0;
		end else begin
			// one product per cycle, always registered
			prod_q <= mul_a * mul_b;

			// drop the result once the far side has taken it, unless a new one
			// takes its place this cycle
			if (quat_valid_q && !quat_stall && state_q != S_DONE) begin
				quat_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						in_q        <= sample;
						dt_q        <= sample.tick_now - last_tick_q;
						last_tick_q <= sample.tick_now;
						idx_q       <= '0;
						state_q     <= S_SM_ABS;
					end
				end

				// smoothing: (new + 2*old)/3, truncated toward zero
				S_SM_ABS: begin
					sm_neg_q <= sm_sum[33];
					sm_mag_q <= sm_sum[33] ? 33'(-sm_sum) : sm_sum[32:0];
					state_q  <= S_SM_MUL;
				end
				S_SM_MUL: begin
					state_q <= S_SM_FIX;
				end
				S_SM_FIX: begin
					// the reciprocal is exact for dividends below 2^33
					smp_q[idx_q] <= sm_neg_q ? -$signed(prod_q[64:33]) : prod_q[64:33];
					if (idx_q == 3'd5) begin
						idx_q   <= '0;
						state_q <= S_GY_MUL;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_SM_ABS;
					end
				end

				// gyro to rad/s
				S_GY_MUL: begin
					state_q <= S_GY_WR;
				end
				S_GY_WR: begin
					g_q[idx_q[1:0]] <= prod_q[63:32];
					if (idx_q == 3'd2) begin
						state_q <= S_H_MUL;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_GY_MUL;
					end
				end

				// half the elapsed time, saturated just under one second
				S_H_MUL: begin
					state_q <= S_H_WR;
				end
				S_H_WR: begin
					h_q   <= (prod_q[63:32] != '0) ? 32'hffffffff : prod_q[31:0];
					idx_q <= '0;
					acc_q <= '0;
					if (smp_q[0] == '0 && smp_q[1] == '0 && smp_q[2] == '0) begin
						invalid_q <= 1'b1;
						for (int i = 0; i < 3; i++) e_q[i] <= '0;
						state_q   <= S_W_MUL;
					end else begin
						invalid_q <= 1'b0;
						state_q   <= S_AS_MUL;
					end
				end

				// squared length of the acceleration
				S_AS_MUL: begin
					state_q <= S_AS_ACC;
				end
				S_AS_ACC: begin
					acc_q <= acc_q + prod_q;
					if (idx_q == 3'd2) begin
						ns_m_q  <= 64'(acc_q + prod_q);
						ns_j_q  <= '0;
						pass_q  <= 1'b0;
						state_q <= S_IS_NORM;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_AS_MUL;
					end
				end

				// inverse square root: scale by 4^-j into [2^60, 2^62)
				S_IS_NORM: begin
					if (ns_m_q[63:62] != 2'b00) begin
						ns_m_q <= ns_m_q >> 2;
						ns_j_q <= ns_j_q + 6'sd1;
					end else if (ns_m_q[63:52] == '0) begin
						ns_m_q <= ns_m_q << 8;
						ns_j_q <= ns_j_q - 6'sd4;
					end else if (ns_m_q[61:60] == 2'b00) begin
						ns_m_q <= ns_m_q << 2;
						ns_j_q <= ns_j_q - 6'sd1;
					end else begin
						state_q <= S_IS_SEED;
					end
				end
				S_IS_SEED: begin
					x_q     <= seed_x;
					sh_q    <= 5'(ns_j_q + 6'sd30);
					state_q <= S_IS_Y;
				end
				S_IS_Y: begin
					if (!x_q[31]) begin
						y_q <= ONE_Q30[31:0] - prod_q[61:30];
					end else begin
						y_q <= CHORD_HI_BASE - prod_q[61:30];
					end
					nstep_q <= '0;
					state_q <= S_NT_SQ;
				end
				S_NT_SQ: begin
					state_q <= S_NT_XY;
				end
				S_NT_XY: begin
					state_q <= S_NT_T;
				end
				S_NT_T: begin
					tn_q    <= (xy2 < THREE_Q30) ? 32'(THREE_Q30 - xy2) : 32'd0;
					state_q <= S_NT_YT;
				end
				S_NT_YT: begin
					state_q <= S_NT_WR;
				end
				S_NT_WR: begin
					y_q   <= prod_q[62:31];
					idx_q <= '0;
					if (nstep_q == NsLast) begin
						state_q <= pass_q ? S_Q_MUL : S_U_MUL;
					end else begin
						nstep_q <= nstep_q + 1'b1;
						state_q <= S_NT_SQ;
					end
				end

				// unit acceleration
				S_U_MUL: begin
					state_q <= S_U_WR;
				end
				S_U_WR: begin
					u_q[idx_q[1:0]] <= p_sh[31:0];
					if (idx_q == 3'd2) begin
						k_q     <= '0;
						dst_q   <= '0;
						acc_q   <= '0;
						state_q <= S_V_MUL;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_U_MUL;
					end
				end

				// gravity direction from the attitude
				S_V_MUL: begin
					state_q <= S_V_ACC;
				end
				S_V_ACC: begin
					if (tab_last) begin
						acc_q <= '0;
						if (dst_q == 2'd2) begin
							v_q[dst_q] <= 34'(acc_nxt >>> 30);
							k_q        <= '0;
							dst_q      <= '0;
							state_q    <= S_E_MUL;
						end else begin
							v_q[dst_q] <= 34'(acc_nxt >>> 29);
							k_q        <= k_q + 4'd1;
							dst_q      <= dst_q + 2'd1;
							state_q    <= S_V_MUL;
						end
					end else begin
						acc_q   <= acc_nxt;
						k_q     <= k_q + 4'd1;
						state_q <= S_V_MUL;
					end
				end

				// error: measured direction crossed with predicted gravity
				S_E_MUL: begin
					state_q <= S_E_ACC;
				end
				S_E_ACC: begin
					k_q <= k_q + 4'd1;
					if (tab_last) begin
						acc_q      <= '0;
						e_q[dst_q] <= 34'(acc_nxt >>> 30);
						dst_q      <= dst_q + 2'd1;
						if (dst_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_I_MUL;
						end else begin
							state_q <= S_E_MUL;
						end
					end else begin
						acc_q   <= acc_nxt;
						state_q <= S_E_MUL;
					end
				end

				// integral terms
				S_I_MUL: begin
					state_q <= S_I_GET;
				end
				S_I_GET: begin
					mt_a_q   <= prod_q;
					mt_ret_q <= 1'b0;
					state_q  <= S_MT_ABS;
				end

				// (a * h) >> 32 toward zero, in two partial products
				S_MT_ABS: begin
					mt_neg_q <= mt_a_q[67];
					mt_m_q   <= mt_a_q[67] ? 64'(-mt_a_q) : mt_a_q[63:0];
					state_q  <= S_MT_HI;
				end
				S_MT_HI: begin
					state_q <= S_MT_LO;
				end
				S_MT_LO: begin
					mt_hi_q <= prod_q[63:0];
					state_q <= S_MT_SUM;
				end
				S_MT_SUM: begin
					if (mt_sum > 65'h0_7fff_ffff_ffff_ffff) begin
						mt_r_q <= 64'sh7fff_ffff_ffff_ffff;
					end else begin
						mt_r_q <= mt_sum[63:0];
					end
					state_q <= S_MT_SGN;
				end
				S_MT_SGN: begin
					if (mt_neg_q) begin
						mt_r_q <= -mt_r_q;
					end
					state_q <= mt_ret_q ? S_T_WR : S_I_WR;
				end

				S_I_WR: begin
					int_q[idx_q[1:0]] <= sat32(i_sum);
					if (idx_q == 3'd2) begin
						idx_q   <= '0;
						state_q <= S_W_MUL;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_I_MUL;
					end
				end

				// corrected rate
				S_W_MUL: begin
					state_q <= S_W_WR;
				end
				S_W_WR: begin
					w_q[idx_q[1:0]] <= sat32(w_sum);
					if (idx_q == 3'd2) begin
						k_q     <= '0;
						dst_q   <= '0;
						acc_q   <= '0;
						state_q <= S_T_MUL;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_W_MUL;
					end
				end

				// quaternion rate, one component per group of three products
				S_T_MUL: begin
					state_q <= S_T_ACC;
				end
				S_T_ACC: begin
					k_q <= k_q + 4'd1;
					if (tab_last) begin
						acc_q    <= '0;
						mt_a_q   <= acc_nxt;
						mt_ret_q <= 1'b1;
						state_q  <= S_MT_ABS;
					end else begin
						acc_q   <= acc_nxt;
						state_q <= S_T_MUL;
					end
				end
				S_T_WR: begin
					if (t_sum > 49'sd2147483646) begin
						t_q[dst_q] <= 32'sh7ffffffe;
					end else if (t_sum < -49'sd2147483647) begin
						t_q[dst_q] <= 32'sh80000001;
					end else begin
						t_q[dst_q] <= t_sum[31:0];
					end
					dst_q <= dst_q + 2'd1;
					if (dst_q == 2'd3) begin
						idx_q   <= '0;
						acc_q   <= '0;
						state_q <= S_QS_MUL;
					end else begin
						state_q <= S_T_MUL;
					end
				end

				// squared length of the integrated quaternion
				S_QS_MUL: begin
					state_q <= S_QS_ACC;
				end
				S_QS_ACC: begin
					acc_q <= acc_q + prod_q;
					if (idx_q == 3'd3) begin
						if ((acc_q + prod_q) == '0) begin
							// degenerate: keep the previous attitude
							state_q <= S_DONE;
						end else begin
							ns_m_q  <= 64'(acc_q + prod_q);
							ns_j_q  <= '0;
							pass_q  <= 1'b1;
							state_q <= S_IS_NORM;
						end
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_QS_MUL;
					end
				end

				// renormalise and clamp to +-1
				S_Q_MUL: begin
					state_q <= S_Q_WR;
				end
				S_Q_WR: begin
					if (p_sh > 68'sd1073741824) begin
						att_q[idx_q[1:0]] <= ONE_Q30[31:0];
					end else if (p_sh < -68'sd1073741824) begin
						att_q[idx_q[1:0]] <= -ONE_Q30[31:0];
					end else begin
						att_q[idx_q[1:0]] <= p_sh[31:0];
					end
					if (idx_q == 3'd3) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_Q_MUL;
					end
				end

				// hold until the output register is free
				S_DONE: begin
					if (!quat_valid_q || !quat_stall) begin
						quat_q.quat_w        <= att_q[0];
						quat_q.quat_x        <= att_q[1];
						quat_q.quat_y        <= att_q[2];
						quat_q.quat_z        <= att_q[3];
						quat_q.accel_invalid <= invalid_q;
						quat_valid_q         <= 1'b1;
						state_q              <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
